// ----- rtl/tod_pkg.sv -----
`timescale 1ns / 1ps

package tod_pkg;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_STOP = 2'd2
  } cmd_t;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_COLON = 8'h3A;

  // upper two bits of an ASCII digit when squeezed into six bits
  localparam logic [1:0] DIGIT_HIGH = 2'b11;

  // time of day held as BCD digits
  typedef struct packed {
    logic [3:0] hour_tens;
    logic [3:0] hour_ones;
    logic [3:0] minute_tens;
    logic [3:0] minute_ones;
    logic [3:0] second_tens;
    logic [3:0] second_ones;
  } tod_time_t;

  typedef struct packed {
    logic      ok;
    tod_time_t value;
  } tod_set_t;

  typedef struct packed {
    logic      emit;
    logic      running;
    tod_time_t value;
  } tod_result_t;

endpackage

// ----- rtl/time_of_day_clock_ascii.sv -----
`timescale 1ns / 1ps

// Seconds-of-day wall clock with tick, set and stop commands.
// Slave channel: s_tuser carries the command (0 tick, 1 set, 2 stop, 3 ignored);
// s_tdata carries the eight characters of "HH:MM:SS", used by set only.
// Master channel: one item per tick. m_tuser is the running flag, m_tdata holds
// six ASCII digits of the time after the tick, each kept as its low six bits,
// all zero when stopped. An accepted item waits in the input register and is
// processed out of it into the time state and, for a tick, the result register
// that drives m_tvalid. Throughput: one item per cycle unless a tick stalls on
// m_tready; a single input register feeds the update logic and result register.
// Set and stop produce no item and never wait on the master side.
// Stall: when the result register holds an untaken item and a tick waits in
// the input register, hold the tick and drop s_tready until m_tready frees it.
// Reset: time 00:00:00, clock stopped, both channels empty.
// The time is kept as BCD digits, so a tick is a carry chain over six digits
// and no division is needed to show it.
module time_of_day_clock_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // cmd
  input  logic [63:0] s_tdata,   // hour_tens_char, hour_ones_char, first_sep_char,
                                 // minute_tens_char, minute_ones_char, second_sep_char,
                                 // second_tens_char, second_ones_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [0:0]  m_tuser,   // running
  output logic [39:0] m_tdata    // out_hour_tens, out_hour_ones, out_minute_tens,
                                 // out_minute_ones, out_second_tens, out_second_ones,
                                 // 4 zero bits
);
  import tod_pkg::*;

  // input register
  logic        in_valid;
  cmd_t        in_cmd;
  logic [63:0] in_chars;

  tod_set_t    set;
  tod_result_t result;
  logic        out_free;
  logic        advance;

  assign out_free = !m_tvalid || m_tready;
  // only a tick needs room in the result register
  assign advance  = in_valid && ((in_cmd != CMD_TICK) || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd   <= cmd_t'(s_tuser);
      in_chars <= s_tdata;
    end
  end

  tod_parse u_parse (
    .chars (in_chars),
    .set   (set)
  );

  tod_core u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (advance),
    .cmd    (in_cmd),
    .set    (set),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && result.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      m_tuser <= result.running;
      if (result.running) begin
        m_tdata <= {4'b0000,
                    DIGIT_HIGH, result.value.second_ones,
                    DIGIT_HIGH, result.value.second_tens,
                    DIGIT_HIGH, result.value.minute_ones,
                    DIGIT_HIGH, result.value.minute_tens,
                    DIGIT_HIGH, result.value.hour_ones,
                    DIGIT_HIGH, result.value.hour_tens};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

// ----- rtl/tod_parse.sv -----
`timescale 1ns / 1ps

module tod_parse (
  input  logic [63:0]       chars,
  output tod_pkg::tod_set_t set
);
  import tod_pkg::*;

  logic [7:0] ch [8];
  logic [7:0] digit_ok;
  logic       hours_ok;
  logic       minutes_ok;
  logic       seconds_ok;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ch[i]       = chars[i*8 +: 8];
      digit_ok[i] = (ch[i] >= ASCII_ZERO) && (ch[i] <= ASCII_NINE);
    end
  end

  assign set.value.hour_tens   = ch[0][3:0];
  assign set.value.hour_ones   = ch[1][3:0];
  assign set.value.minute_tens = ch[3][3:0];
  assign set.value.minute_ones = ch[4][3:0];
  assign set.value.second_tens = ch[6][3:0];
  assign set.value.second_ones = ch[7][3:0];

  // hours below 24, minutes and seconds below 60
  assign hours_ok   = (ch[0][3:0] < 4'd2) || ((ch[0][3:0] == 4'd2) && (ch[1][3:0] < 4'd4));
  assign minutes_ok = ch[3][3:0] < 4'd6;
  assign seconds_ok = ch[6][3:0] < 4'd6;

  assign set.ok = digit_ok[0] && digit_ok[1] && digit_ok[3] && digit_ok[4]
                  && digit_ok[6] && digit_ok[7]
                  && (ch[2] == ASCII_COLON) && (ch[5] == ASCII_COLON)
                  && hours_ok && minutes_ok && seconds_ok;

endmodule

// ----- rtl/tod_core.sv -----
`timescale 1ns / 1ps

module tod_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  tod_pkg::cmd_t        cmd,
  input  tod_pkg::tod_set_t    set,
  output tod_pkg::tod_result_t result
);
  import tod_pkg::*;

  tod_time_t now;
  tod_time_t now_next;
  tod_time_t now_inc;
  logic      clock_running;
  logic      clock_running_next;

  // one-second BCD increment, wrapping 23:59:59 to 00:00:00
  always_comb begin
    logic sec_wrap;
    logic sec_tens_wrap;
    logic min_wrap;
    logic min_tens_wrap;
    sec_wrap      = now.second_ones == 4'd9;
    sec_tens_wrap = sec_wrap && (now.second_tens == 4'd5);
    min_wrap      = sec_tens_wrap && (now.minute_ones == 4'd9);
    min_tens_wrap = min_wrap && (now.minute_tens == 4'd5);
    now_inc = now;
    now_inc.second_ones = sec_wrap ? 4'd0 : now.second_ones + 4'd1;
    if (sec_wrap) begin
      now_inc.second_tens = sec_tens_wrap ? 4'd0 : now.second_tens + 4'd1;
    end
    if (sec_tens_wrap) begin
      now_inc.minute_ones = min_wrap ? 4'd0 : now.minute_ones + 4'd1;
    end
    if (min_wrap) begin
      now_inc.minute_tens = min_tens_wrap ? 4'd0 : now.minute_tens + 4'd1;
    end
    if (min_tens_wrap) begin
      if (now.hour_tens == 4'd2 && now.hour_ones == 4'd3) begin
        now_inc.hour_tens = 4'd0;
        now_inc.hour_ones = 4'd0;
      end else if (now.hour_ones == 4'd9) begin
        now_inc.hour_ones = 4'd0;
        now_inc.hour_tens = now.hour_tens + 4'd1;
      end else begin
        now_inc.hour_ones = now.hour_ones + 4'd1;
      end
    end
  end

  always_comb begin
    now_next           = now;
    clock_running_next = clock_running;
    result.emit        = 1'b0;
    result.running     = clock_running;
    result.value       = clock_running ? now_inc : '0;
    case (cmd)
      CMD_TICK: begin
        result.emit = 1'b1;
        if (clock_running) begin
          now_next = now_inc;
        end
      end
      CMD_SET: begin
        clock_running_next = set.ok;
        if (set.ok) begin
          now_next = set.value;
        end
      end
      CMD_STOP: begin
        clock_running_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now           <= '0;
      clock_running <= 1'b0;
    end else if (go) begin
      now           <= now_next;
      clock_running <= clock_running_next;
    end
  end

endmodule
